// ===== design/tvq_pkg.sv =====
// Shared constants, types and a helper function of the Tokhura vector quantizer.
package tvq_pkg;

  localparam int CODEWORDS  = 32;
  localparam int DIMENSION  = 12;
  localparam int COEF_WIDTH = 16;

  // Fixed field widths of the transaction payload
  localparam int CW_W   = 5;
  localparam int POS_W  = 4;
  localparam int ACT_W  = 6;
  localparam int DIST_W = 41;

  // Derived storage and datapath widths
  localparam int CB_DEPTH = CODEWORDS * DIMENSION;
  localparam int CB_AW    = $clog2(CB_DEPTH);
  localparam int TV_AW    = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
  localparam int SQ_W     = 2 * COEF_WIDTH;
  localparam int WT_W     = 6;
  localparam int PROD_W   = SQ_W + WT_W;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(CODEWORDS);

  // Register map: one register, index taken from paddr[2]
  localparam logic REG_ACTIVE = 1'b0;

  typedef enum logic {
    OP_CODEBOOK = 1'b0,
    OP_TEST     = 1'b1
  } op_t;

  localparam int WEIGHT_COUNT = 12;
  localparam logic [WT_W-1:0] WEIGHTS [WEIGHT_COUNT] = '{
    6'd1, 6'd3, 6'd7, 6'd13, 6'd19, 6'd22, 6'd25, 6'd33, 6'd42, 6'd50, 6'd56, 6'd61
  };

  // Positions past the table reuse the last weight
  function automatic logic [WT_W-1:0] weight_at(input logic [TV_AW-1:0] pos);
    logic [WT_W-1:0] w;
    w = WEIGHTS[WEIGHT_COUNT-1];
    for (int i = 0; i < WEIGHT_COUNT; i++) begin
      if (32'(pos) == i) begin
        w = WEIGHTS[i];
      end
    end
    return w;
  endfunction

  // Tag that travels down the distance pipeline with each coefficient pair
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             lastcw;
    logic [TV_AW-1:0] pos;
    logic [CW_W-1:0]  cw;
  } tag_t;

  // Outcome of one search
  typedef struct packed {
    logic              done;
    logic [CW_W-1:0]   index;
    logic [DIST_W-1:0] distance;
  } search_res_t;

endpackage

// ===== design/tvq_in_if.sv =====
// Input channel: one coefficient transaction.
interface tvq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic [tvq_pkg::CW_W-1:0]              codeword_index;
  logic [tvq_pkg::POS_W-1:0]             coef_index;
  logic signed [tvq_pkg::COEF_WIDTH-1:0] coef_value;

  modport source(output valid, output op, output codeword_index, output coef_index,
                 output coef_value, input ready);
  modport sink(input valid, input op, input codeword_index, input coef_index,
               input coef_value, output ready);
endinterface

// ===== design/tvq_out_if.sv =====
// Output channel: nearest codeword and its distance.
interface tvq_out_if;
  logic                        valid;
  logic                        ready;
  logic [tvq_pkg::CW_W-1:0]    nearest_index;
  logic [tvq_pkg::DIST_W-1:0]  nearest_distance;

  modport source(output valid, output nearest_index, output nearest_distance, input ready);
  modport sink(input valid, input nearest_index, input nearest_distance, output ready);
endinterface

// ===== design/tokhura_vector_quantizer_top.sv =====
// Top level of the Tokhura-distance vector quantizer.
// Codebook and test-vector coefficients arrive one per transaction and are stored
// in two single-port-read RAMs. The transaction that carries the last test
// coefficient starts a search that reads one coefficient pair per cycle from the
// codebook RAM and feeds a single multiply-accumulate pipeline; a search covers
// every position of each active codeword (32 by default). No further input is
// taken during a search; a finished result waits in the output register while
// new input is accepted. Entries of either store that were never written read as
// arbitrary values. The active_codewords register sits at byte address 0: 0
// searches codeword 0 only, values above 32 search all 32.
module tokhura_vector_quantizer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  tvq_in_if.sink                       item,
  tvq_out_if.source                    result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  state_t                          state;
  logic [tvq_pkg::ACT_W-1:0]       active_codewords;
  logic [tvq_pkg::CB_AW-1:0]       rd_addr;
  logic [tvq_pkg::TV_AW-1:0]       rd_pos;
  logic [tvq_pkg::CW_W-1:0]        rd_cw;
  logic [tvq_pkg::CW_W-1:0]        last_cw;
  logic [tvq_pkg::CW_W-1:0]        last_cw_next;
  logic                            out_valid;
  logic [tvq_pkg::CW_W-1:0]        out_index;
  logic [tvq_pkg::DIST_W-1:0]      out_dist;

  logic                            accept;
  logic                            pos_ok;
  logic                            cw_ok;
  logic                            cb_we;
  logic                            tv_we;
  logic                            start;
  logic                            issue_end;
  logic                            out_free;
  logic                            out_load;
  logic [tvq_pkg::CB_AW-1:0]       cb_waddr;
  logic [tvq_pkg::COEF_WIDTH-1:0]  cb_rdata;
  logic [tvq_pkg::COEF_WIDTH-1:0]  tv_rdata;
  logic                            cfg_we;
  tvq_pkg::tag_t                   t0, t1;
  tvq_pkg::search_res_t            res;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == tvq_pkg::REG_ACTIVE);
  assign prdata = (paddr[2] == tvq_pkg::REG_ACTIVE) ? 32'(active_codewords) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_codewords <= tvq_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_codewords <= pwdata[tvq_pkg::ACT_W-1:0];
    end
  end

  // Decode the input transaction
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign pos_ok     = item.coef_index < tvq_pkg::POS_W'(tvq_pkg::DIMENSION);
  assign cw_ok      = {1'b0, item.codeword_index} < (tvq_pkg::CW_W + 1)'(tvq_pkg::CODEWORDS);
  assign cb_we      = accept && (item.op == tvq_pkg::OP_CODEBOOK) && pos_ok && cw_ok;
  assign tv_we      = accept && (item.op == tvq_pkg::OP_TEST) && pos_ok;
  assign start      = accept && (item.op == tvq_pkg::OP_TEST)
                   && (item.coef_index == tvq_pkg::POS_W'(tvq_pkg::DIMENSION - 1));
  assign cb_waddr   = tvq_pkg::CB_AW'(item.codeword_index) * tvq_pkg::CB_AW'(tvq_pkg::DIMENSION)
                    + tvq_pkg::CB_AW'(item.coef_index);

  // Saturate the active count to a last codeword index
  always_comb begin
    if (active_codewords == '0) begin
      last_cw_next = '0;
    end else if (active_codewords > tvq_pkg::ACT_W'(tvq_pkg::CODEWORDS)) begin
      last_cw_next = tvq_pkg::CW_W'(tvq_pkg::CODEWORDS - 1);
    end else begin
      last_cw_next = tvq_pkg::CW_W'(active_codewords - 1'b1);
    end
  end

  // Storage
  tvq_ram #(.WIDTH(tvq_pkg::COEF_WIDTH), .DEPTH(tvq_pkg::CB_DEPTH)) u_codebook (
    .clk   (clk),
    .we    (cb_we),
    .waddr (cb_waddr),
    .wdata (item.coef_value),
    .raddr (rd_addr),
    .rdata (cb_rdata)
  );

  tvq_ram #(.WIDTH(tvq_pkg::COEF_WIDTH), .DEPTH(tvq_pkg::DIMENSION)) u_test_vector (
    .clk   (clk),
    .we    (tv_we),
    .waddr (tvq_pkg::TV_AW'(item.coef_index)),
    .wdata (item.coef_value),
    .raddr (rd_pos),
    .rdata (tv_rdata)
  );

  // Tag of the read issued this cycle; delay it to meet the read data
  always_comb begin
    t0.valid  = (state == ST_ISSUE);
    t0.first  = (rd_pos == '0);
    t0.last   = (rd_pos == tvq_pkg::TV_AW'(tvq_pkg::DIMENSION - 1));
    t0.lastcw = (rd_cw == last_cw);
    t0.pos    = rd_pos;
    t0.cw     = rd_cw;
  end
  assign issue_end = t0.last && t0.lastcw;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
    end else begin
      t1 <= t0;
    end
  end

  tvq_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (t1),
    .tv_data (tv_rdata),
    .cb_data (cb_rdata),
    .res     (res)
  );

  // Sequencer and output register
  assign out_free = !out_valid || result.ready;
  assign out_load = out_free && (((state == ST_DRAIN) && res.done) || (state == ST_HOLD));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_addr   <= '0;
      rd_pos    <= '0;
      rd_cw     <= '0;
      last_cw   <= '0;
    end else begin
      // Load a finished result when the output register is free, else drop a taken one
      if (out_load) begin
        out_valid <= 1'b1;
        out_index <= res.index;
        out_dist  <= res.distance;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rd_addr <= '0;
            rd_pos  <= '0;
            rd_cw   <= '0;
            last_cw <= last_cw_next;
            state   <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          rd_addr <= rd_addr + 1'b1;
          if (t0.last) begin
            rd_pos <= '0;
            rd_cw  <= rd_cw + 1'b1;
          end else begin
            rd_pos <= rd_pos + 1'b1;
          end
          if (issue_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res.done) begin
            state <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid            = out_valid;
  assign result.nearest_index    = out_index;
  assign result.nearest_distance = out_dist;

endmodule

// ===== design/tvq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tvq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tvq_dist.sv =====
// Distance pipeline: difference, square, weight, accumulate and running argmin.
module tvq_dist (
  input  logic                              clk,
  input  logic                              rst,
  input  tvq_pkg::tag_t                     tag_in,
  input  logic [tvq_pkg::COEF_WIDTH-1:0]    tv_data,
  input  logic [tvq_pkg::COEF_WIDTH-1:0]    cb_data,
  output tvq_pkg::search_res_t              res
);

  tvq_pkg::tag_t t2, t3, t4, t5;

  logic signed [tvq_pkg::COEF_WIDTH:0]  diff;
  logic signed [tvq_pkg::COEF_WIDTH:0]  diff_neg;
  logic [tvq_pkg::COEF_WIDTH-1:0]       mag;
  logic [tvq_pkg::SQ_W-1:0]             sq;
  logic [tvq_pkg::PROD_W-1:0]           prod;
  logic [tvq_pkg::DIST_W-1:0]           acc;
  logic [tvq_pkg::DIST_W-1:0]           best;
  logic [tvq_pkg::CW_W-1:0]             best_idx;
  logic                                 done;

  // Sign-extended difference of the two coefficients and its magnitude
  always_comb begin
    diff     = {tv_data[tvq_pkg::COEF_WIDTH-1], tv_data}
             - {cb_data[tvq_pkg::COEF_WIDTH-1], cb_data};
    diff_neg = -diff;
  end

  // Advance the tags
  always_ff @(posedge clk) begin
    if (rst) begin
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
    end else begin
      t2 <= tag_in;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
    end
  end

  // Arithmetic stages: magnitude, square, weight and accumulate; square and weight use one multiplier each
  always_ff @(posedge clk) begin
    mag  <= diff[tvq_pkg::COEF_WIDTH] ? diff_neg[tvq_pkg::COEF_WIDTH-1:0]
                                      : diff[tvq_pkg::COEF_WIDTH-1:0];
    sq   <= tvq_pkg::SQ_W'(mag) * tvq_pkg::SQ_W'(mag);
    prod <= tvq_pkg::PROD_W'(sq) * tvq_pkg::PROD_W'(tvq_pkg::weight_at(t3.pos));
    if (t4.valid) begin
      acc <= t4.first ? tvq_pkg::DIST_W'(prod) : acc + tvq_pkg::DIST_W'(prod);
    end
  end

  // Keep the lowest distance; strict compare lets the lowest index win ties
  always_ff @(posedge clk) begin
    if (t5.valid && t5.last && (t5.cw == '0 || acc < best)) begin
      best     <= acc;
      best_idx <= t5.cw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t5.valid && t5.last && t5.lastcw;
    end
  end

  assign res.done     = done;
  assign res.index    = best_idx;
  assign res.distance = best;

endmodule

// ===== design/tvq_checker.sv =====
// Port-level checker of the Tokhura vector quantizer and its bind.
module tvq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [2:0]                   paddr,
  input logic [31:0]                  pwdata,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_op,
  input logic [tvq_pkg::POS_W-1:0]    in_coef_index,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tvq_pkg::CW_W-1:0]     out_index,
  input logic [tvq_pkg::DIST_W-1:0]   out_dist
);

  logic [tvq_pkg::ACT_W-1:0] active;
  logic [tvq_pkg::CW_W-1:0]  limit;
  logic                      pending;
  logic                      search_start;

  assign search_start = in_valid && in_ready && (in_op == tvq_pkg::OP_TEST)
                     && (in_coef_index == tvq_pkg::POS_W'(tvq_pkg::DIMENSION - 1));

  // Shadow the active-count register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= tvq_pkg::ACTIVE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == tvq_pkg::REG_ACTIVE)) begin
      active <= pwdata[tvq_pkg::ACT_W-1:0];
    end
  end

  always_comb begin
    if (active == '0) begin
      limit = '0;
    end else if (active > tvq_pkg::ACT_W'(tvq_pkg::CODEWORDS)) begin
      limit = tvq_pkg::CW_W'(tvq_pkg::CODEWORDS - 1);
    end else begin
      limit = tvq_pkg::CW_W'(active - 1'b1);
    end
  end

  // Track a search whose result has not shown yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (search_start) begin
      pending <= 1'b1;
    end else if (out_valid && !$past(out_valid)) begin
      pending <= 1'b0;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_dist))
    else $error("result dropped or changed while stalled");

  a_result_needs_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> pending)
    else $error("result without a search");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_index <= limit)
    else $error("nearest index beyond active codewords");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    search_start |=> !in_ready)
    else $error("input taken while a search runs");

endmodule

bind tokhura_vector_quantizer_top tvq_checker u_tvq_checker (
  .clk           (clk),
  .rst           (rst),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .in_valid      (item.valid),
  .in_ready      (item.ready),
  .in_op         (item.op),
  .in_coef_index (item.coef_index),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_index     (result.nearest_index),
  .out_dist      (result.nearest_distance)
);
